/* src/ucnt_pkg.sv */
package ucnt_pkg;

  // Register widths
  localparam int unsigned CntW  = 32;
  localparam int unsigned PscW  = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned OpW   = 2;

  // Status and enable bit positions
  localparam int unsigned FlagUpdate  = 0;
  localparam int unsigned FlagCompare = 1;

  // Control register bit positions
  localparam int unsigned CtrlEnBit  = 0;
  localparam int unsigned CtrlOpuBit = 2;

  // Event generate bit position
  localparam int unsigned EgrUpdateBit = 0;

  typedef enum logic [OpW-1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  typedef enum logic [IdxW-1:0] {
    REG_CTRL     = 3'd0,
    REG_IRQ_EN   = 3'd1,
    REG_STATUS   = 3'd2,
    REG_EVT_GEN  = 3'd3,
    REG_COUNT    = 3'd4,
    REG_PRESCALE = 3'd5,
    REG_RELOAD   = 3'd6,
    REG_COMPARE  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    op_e             op;
    reg_idx_e        reg_index;
    logic [DataW-1:0] wdata;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] rdata;
    logic             irq;
  } out_item_t;

endpackage

/* src/up_counter_timer_with_compare_core.sv */
// Channel  | valid         | stall         | payload
// ---------+---------------+---------------+--------------------------
// in       | in_valid_i    | in_stall_o    | in_item_i  (op, reg, data)
// out      | out_valid_o   | out_stall_i   | out_item_o (rdata, irq)
//
// Each transfer is handled at its accepting edge: the timer state is updated
// and the result lands in the output register at that edge.
// One item per cycle is sustained while the output side does not stall; there is a single output register.
// The input stalls only while a result is held and the output side stalls.
// Reset sets reload to all ones, clears the rest of the timer state and empties the output register.
module up_counter_timer_with_compare_core import ucnt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic            cnt_en_q, cnt_en_d;
  logic            opu_q, opu_d;
  logic [1:0]      irq_en_q, irq_en_d;
  logic [1:0]      flags_q, flags_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PscW-1:0] psc_buf_q, psc_buf_d;
  logic [PscW-1:0] psc_act_q, psc_act_d;
  logic [PscW-1:0] psc_tick_q, psc_tick_d;
  logic [CntW-1:0] reload_q, reload_d;
  logic [CntW-1:0] compare_q, compare_d;

  logic            out_valid_q;
  out_item_t       out_item_q, out_item_d;
  logic            accept;
  logic [CntW-1:0] wdata_cnt;
  logic [CntW-1:0] tick_count;

  // Handshake: take a transfer whenever the output register is free or draining
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign wdata_cnt = CntW'(in_item_i.wdata);

  // Step the timer state for one transfer
  always_comb begin
    cnt_en_d   = cnt_en_q;
    opu_d      = opu_q;
    irq_en_d   = irq_en_q;
    flags_d    = flags_q;
    count_d    = count_q;
    psc_buf_d  = psc_buf_q;
    psc_act_d  = psc_act_q;
    psc_tick_d = psc_tick_q;
    reload_d   = reload_q;
    compare_d  = compare_q;
    tick_count = count_q;
    out_item_d.rdata = '0;

    unique case (in_item_i.op)
      OP_TICK: begin
        if (cnt_en_q) begin
          if (psc_tick_q < psc_act_q) begin
            psc_tick_d = psc_tick_q + 1'b1;
          end else begin
            psc_tick_d = '0;
            // Wrap at reload, else advance
            if (count_q == reload_q) begin
              tick_count = '0;
              flags_d[FlagUpdate] = 1'b1;
              psc_act_d = psc_buf_q;
            end else begin
              tick_count = count_q + 1'b1;
            end
            count_d = tick_count;
            if (tick_count == compare_q) begin
              flags_d[FlagCompare] = 1'b1;
            end
          end
        end
      end
      OP_READ: begin
        unique case (in_item_i.reg_index)
          REG_CTRL: begin
            out_item_d.rdata[CtrlEnBit]  = cnt_en_q;
            out_item_d.rdata[CtrlOpuBit] = opu_q;
          end
          REG_IRQ_EN:   out_item_d.rdata = DataW'(irq_en_q);
          REG_STATUS:   out_item_d.rdata = DataW'(flags_q);
          REG_EVT_GEN:  out_item_d.rdata = '0;
          REG_COUNT:    out_item_d.rdata = DataW'(count_q);
          REG_PRESCALE: out_item_d.rdata = DataW'(psc_buf_q);
          REG_RELOAD:   out_item_d.rdata = DataW'(reload_q);
          REG_COMPARE:  out_item_d.rdata = DataW'(compare_q);
        endcase
      end
      OP_WRITE: begin
        unique case (in_item_i.reg_index)
          REG_CTRL: begin
            cnt_en_d = in_item_i.wdata[CtrlEnBit];
            opu_d    = in_item_i.wdata[CtrlOpuBit];
          end
          REG_IRQ_EN: irq_en_d = in_item_i.wdata[1:0];
          // Clear flags written as zero
          REG_STATUS: flags_d = flags_q & in_item_i.wdata[1:0];
          REG_EVT_GEN: begin
            if (in_item_i.wdata[EgrUpdateBit]) begin
              count_d    = '0;
              psc_tick_d = '0;
              psc_act_d  = psc_buf_q;
              if (!opu_q) begin
                flags_d[FlagUpdate] = 1'b1;
              end
            end
          end
          REG_COUNT:    count_d   = wdata_cnt;
          REG_PRESCALE: psc_buf_d = PscW'(in_item_i.wdata);
          REG_RELOAD:   reload_d  = wdata_cnt;
          REG_COMPARE:  compare_d = wdata_cnt;
        endcase
      end
      default: begin
        // Unused operation: leave the state alone
      end
    endcase

    out_item_d.irq = |(flags_d & irq_en_d);
  end

  // Timer state registers, advanced only on an accepted transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_en_q   <= 1'b0;
      opu_q      <= 1'b0;
      irq_en_q   <= '0;
      flags_q    <= '0;
      count_q    <= '0;
      psc_buf_q  <= '0;
      psc_act_q  <= '0;
      psc_tick_q <= '0;
      reload_q   <= '1;
      compare_q  <= '0;
    end else if (accept) begin
      cnt_en_q   <= cnt_en_d;
      opu_q      <= opu_d;
      irq_en_q   <= irq_en_d;
      flags_q    <= flags_d;
      count_q    <= count_d;
      psc_buf_q  <= psc_buf_d;
      psc_act_q  <= psc_act_d;
      psc_tick_q <= psc_tick_d;
      reload_q   <= reload_d;
      compare_q  <= compare_d;
    end
  end

  // Output register valid: fill on accept, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

/* tb/timer_result_check.sv */
module timer_result_check import ucnt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  // Shadow copy of the timer state
  logic            cnt_en;
  logic            ovf_only;
  logic [1:0]      irq_en;
  logic [1:0]      flags;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] reload;
  logic [CntW-1:0] compare;
  logic [PscW-1:0] psc_buf;
  logic [PscW-1:0] psc_act;
  logic [PscW-1:0] psc_div;

  // Results owed by the block, oldest first
  out_item_t timer_results[$];
  out_item_t want;

  // Clear the shadow state to its power-on values
  function automatic void timer_clear();
    cnt_en   = 1'b0;
    ovf_only = 1'b0;
    irq_en   = '0;
    flags    = '0;
    cnt      = '0;
    reload   = '1;
    compare  = '0;
    psc_buf  = '0;
    psc_act  = '0;
    psc_div  = '0;
  endfunction

  // Apply one transfer to the shadow state and return the result it owes
  function automatic out_item_t timer_step(input in_item_t it);
    out_item_t res;
    res = '0;
    case (it.op)
      OP_TICK: begin
        if (cnt_en) begin
          if (psc_div < psc_act) begin
            psc_div = psc_div + 1'b1;
          end else begin
            psc_div = '0;
            // Overflow only on equality; above reload the counter wraps silently
            if (cnt == reload) begin
              cnt                = '0;
              flags[FlagUpdate]  = 1'b1;
              psc_act            = psc_buf;
            end else begin
              cnt = cnt + 1'b1;
            end
            if (cnt == compare) flags[FlagCompare] = 1'b1;
          end
        end
      end
      OP_READ: begin
        case (it.reg_index)
          REG_CTRL: begin
            res.rdata[CtrlEnBit]  = cnt_en;
            res.rdata[CtrlOpuBit] = ovf_only;
          end
          REG_IRQ_EN:   res.rdata = DataW'(irq_en);
          REG_STATUS:   res.rdata = DataW'(flags);
          REG_COUNT:    res.rdata = DataW'(cnt);
          REG_PRESCALE: res.rdata = DataW'(psc_buf);
          REG_RELOAD:   res.rdata = DataW'(reload);
          REG_COMPARE:  res.rdata = DataW'(compare);
          default:      res.rdata = '0;
        endcase
      end
      OP_WRITE: begin
        case (it.reg_index)
          REG_CTRL: begin
            cnt_en   = it.wdata[CtrlEnBit];
            ovf_only = it.wdata[CtrlOpuBit];
          end
          REG_IRQ_EN: irq_en = it.wdata[1:0];
          // Clear the flags written as zero
          REG_STATUS: flags = flags & it.wdata[1:0];
          REG_EVT_GEN: begin
            if (it.wdata[EgrUpdateBit]) begin
              cnt     = '0;
              psc_div = '0;
              psc_act = psc_buf;
              if (!ovf_only) flags[FlagUpdate] = 1'b1;
            end
          end
          REG_COUNT:    cnt     = it.wdata[CntW-1:0];
          REG_PRESCALE: psc_buf = it.wdata[PscW-1:0];
          REG_RELOAD:   reload  = it.wdata[CntW-1:0];
          default:      compare = it.wdata[CntW-1:0];
        endcase
      end
      default: ;
    endcase
    res.irq = |(flags & irq_en);
    return res;
  endfunction

  // Compare each output transfer with the oldest owed result, then queue new ones
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_clear();
      timer_results.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (timer_results.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: result with none owed: rdata %h irq %b",
                     $realtime, out_item_i.rdata, out_item_i.irq);
        end else begin
          want = timer_results.pop_front();
          if (want.rdata !== out_item_i.rdata || want.irq !== out_item_i.irq) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display("%0t: mismatch: rdata exp %h got %h, irq exp %b got %b",
                       $realtime, want.rdata, out_item_i.rdata, want.irq,
                       out_item_i.irq);
          end
        end
      end
      if (in_valid_i && !in_stall_i) timer_results.push_back(timer_step(in_item_i));
      pending_count_o = timer_results.size();
    end
  end

endmodule

/* tb/tb_top.sv */
module tb_top import ucnt_pkg::*; ();

  localparam logic [OpW-1:0] OpUnused  = 2'd3;
  localparam int unsigned    RandItems = 900;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  int unsigned mismatches;
  int unsigned pending;

  // Idling is switched off for the closing stretch of the run
  logic        idle_on   = 1'b1;
  int          stall_run = 0;
  int unsigned n_sent    = 0;
  int unsigned n_tick    = 0;
  int unsigned n_read    = 0;
  int unsigned n_write   = 0;
  int unsigned n_unused  = 0;
  int unsigned rand_base;
  int unsigned drain;

  always #5 clk = ~clk;

  up_counter_timer_with_compare_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  timer_result_check u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_item_i       (out_item),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  // Stall the output in bursts of random length, with free runs between
  always @(negedge clk) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else if (!out_stall && $urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_run = $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
      stall_run = $urandom_range(0, 14);
    end
  end

  // Offer one transfer, with an optional idle burst ahead of it; return at a falling edge
  task automatic send_item(input logic [OpW-1:0] op, input reg_idx_e idx,
                           input logic [DataW-1:0] data);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= in_item_t'({op, idx, data});
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    n_sent++;
    case (op)
      OP_TICK:  n_tick++;
      OP_READ:  n_read++;
      OP_WRITE: n_write++;
      default:  n_unused++;
    endcase
  endtask

  function automatic reg_idx_e any_reg();
    return reg_idx_e'(3'($urandom_range(0, 7)));
  endfunction

  task automatic wr(input reg_idx_e idx, input logic [DataW-1:0] data);
    send_item(OP_WRITE, idx, data);
  endtask

  task automatic rd(input reg_idx_e idx);
    send_item(OP_READ, idx, $urandom);
  endtask

  task automatic tick(input int unsigned n);
    repeat (n) send_item(OP_TICK, any_reg(), $urandom);
  endtask

  // Mostly ticks, with reads, flag clears, counter pokes and random register writes mixed in
  task automatic run_op();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 13) tick(1);
    else if (pick < 15) rd(any_reg());
    else if (pick < 17) wr(REG_STATUS, $urandom);
    else if (pick == 17) begin
      case ($urandom_range(0, 2))
        0:       wr(REG_COUNT, $urandom_range(0, 24));
        1:       wr(REG_COUNT, 32'hffff_ffff - $urandom_range(0, 4));
        default: wr(REG_COUNT, $urandom);
      endcase
    end else if (pick == 18) wr(REG_EVT_GEN, $urandom);
    else wr(any_reg(), $urandom);
  endtask

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset values, masking, event generate, overflow, compare at zero, wrap
    rd(REG_RELOAD);
    wr(REG_PRESCALE, 32'hffff_ffff);
    rd(REG_PRESCALE);
    wr(REG_PRESCALE, 32'h1);
    wr(REG_IRQ_EN, 32'hffff_ffff);
    wr(REG_EVT_GEN, 32'hffff_fffe);
    wr(REG_EVT_GEN, 32'h1);
    wr(REG_STATUS, 32'hffff_fffe);
    wr(REG_RELOAD, 32'h2);
    wr(REG_COMPARE, 32'h0);
    wr(REG_CTRL, 32'hffff_ffff);
    rd(REG_CTRL);
    tick(6);
    send_item(OpUnused, REG_COUNT, 32'hffff_ffff);
    rd(REG_STATUS);
    wr(REG_COUNT, 32'hffff_ffff);
    tick(2);
    rd(REG_COUNT);
    wr(REG_EVT_GEN, 32'h1);
    wr(REG_STATUS, 32'h0);
    rd(REG_EVT_GEN);
    wr(REG_CTRL, 32'h0);
    tick(1);

    // Random: set up a short counting scenario, run it, and sprinkle in noise
    rand_base = n_sent;
    while (n_sent < rand_base + RandItems) begin
      if (n_sent > rand_base + RandItems - 150) idle_on = 1'b0;
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 5) == 0) wr(REG_PRESCALE, $urandom);
        else wr(REG_PRESCALE, $urandom_range(0, 3));
        wr(REG_RELOAD, $urandom_range(0, 24));
        wr(REG_COMPARE, $urandom_range(0, 24));
        wr(REG_IRQ_EN, $urandom);
        wr(REG_CTRL, ($urandom & ~32'h1) | ($urandom_range(0, 7) != 0));
        if ($urandom_range(0, 1) == 0) wr(REG_EVT_GEN, $urandom);
        repeat ($urandom_range(10, 60)) run_op();
      end else begin
        repeat ($urandom_range(1, 10))
          send_item(OpW'($urandom_range(0, 3)), any_reg(), $urandom);
      end
    end
    in_valid <= 1'b0;

    // Drain the owed results, then let the output register settle
    drain = 0;
    while (pending != 0 && drain < 1000) begin
      @(negedge clk);
      drain++;
    end
    repeat (4) @(negedge clk);

    $display("Sent %0d transfers: %0d ticks, %0d reads, %0d writes, %0d unused-op items",
             n_sent, n_tick, n_read, n_write, n_unused);
    $display("Mismatches %0d, results still owed %0d", mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
